// ----- src/loop_event_recorder_player_macros.svh -----
// Assertion macros for loop_event_recorder_player.
// The clock is clk and the synchronous reset is rst in every module that uses them.
`ifndef LOOP_EVENT_RECORDER_PLAYER_MACROS_SVH
`define LOOP_EVENT_RECORDER_PLAYER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

// ----- src/lerp_pkg.sv -----
`timescale 1ns / 1ps
package lerp_pkg;

  localparam int MAX_NOTES = 64;
  localparam int TIME_BITS = 32;
  localparam int IDX_BITS  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CNT_BITS  = $clog2(MAX_NOTES + 1);

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_KEY    = 2'd1,
    REQ_RECORD = 2'd2,
    REQ_PLAY   = 2'd3
  } req_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  key_code;
    logic [15:0] pitch_value;
  } req_t;

  typedef struct packed {
    logic [7:0]  note_key;
    logic [15:0] note_pitch;
    logic        last_note;
  } rsp_t;

  // One stored note as it sits in the note memory.
  typedef struct packed {
    logic [7:0]           key;
    logic [15:0]          pitch;
    logic [TIME_BITS-1:0] stamp;
  } note_t;

  localparam int NOTE_BITS = $bits(note_t);

endpackage

// ----- src/lerp_ram.sv -----
`timescale 1ns / 1ps
module lerp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/lerp_cmp.sv -----
`timescale 1ns / 1ps
module lerp_cmp import lerp_pkg::*; (
  input  logic [TIME_BITS:0] lhs,
  input  logic [TIME_BITS:0] rhs,
  output logic               le
);

  // Unsigned less-or-equal, one guard bit wider than a time stamp.
  assign le = (lhs <= rhs);

endmodule

// ----- src/loop_event_recorder_player.sv -----
// A tick with playback running first updates the loop position in WRAP (skipped on the
// first tick of a playback), then reads each stored note in SCAN and tests it in CHK, and
// ends when no note is left or a note is found not yet due; other requests finish in IDLE.
// Throughput: one request at a time; busy stays high while a tick walks its notes.
// Each result is registered from its decision and cannot be stalled.
// Reset (rst, synchronous, active high) clears the control state, not the note memory.
`timescale 1ns / 1ps
`include "loop_event_recorder_player_macros.svh"
module loop_event_recorder_player import lerp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic result_valid,
  output rsp_t result
);

  // The sequencer walks the due notes of one tick through a single compare unit.
  // WRAP uses it to test the advanced loop position against the loop length;
  // CHK uses it to test a note stamp against the loop position.
  typedef enum logic [1:0] {
    IDLE,
    WRAP,
    SCAN,
    CHK
  } state_t;

  state_t state;

  logic                 is_recording;
  logic                 is_playing;
  logic                 play_fresh;
  logic [TIME_BITS-1:0] record_clock;
  logic [TIME_BITS-1:0] loop_length;
  logic [TIME_BITS-1:0] play_position;
  logic [CNT_BITS-1:0]  next_note;
  logic [CNT_BITS-1:0]  note_count;

  // A due note is held back one step so that the last one of a tick can be marked.
  logic  have_pend;
  note_t pend;

  logic      accept;
  req_code_t code;
  logic      store_key;
  note_t     wr_note;
  note_t     rd_note;
  logic      rd_en;
  logic [NOTE_BITS-1:0] rd_word;

  logic [TIME_BITS:0] pos_inc;
  logic [TIME_BITS:0] cmp_lhs;
  logic [TIME_BITS:0] cmp_rhs;
  logic               cmp_le;
  logic               more_notes;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;
  assign code   = req_code_t'(request.req_type);

  assign store_key = accept && (code == REQ_KEY) && is_recording
                     && (note_count < CNT_BITS'(MAX_NOTES));

  assign wr_note.key   = request.key_code;
  assign wr_note.pitch = request.pitch_value;
  assign wr_note.stamp = record_clock;

  assign more_notes = (next_note < note_count);
  assign rd_en      = (state == SCAN) && more_notes;
  assign rd_note    = note_t'(rd_word);

  // The memory takes notes in recording order; playback reads them in the same order.
  lerp_ram #(
    .WIDTH (NOTE_BITS),
    .DEPTH (MAX_NOTES)
  ) u_notes (
    .clk   (clk),
    .we    (store_key),
    .waddr (note_count[IDX_BITS-1:0]),
    .wdata (wr_note),
    .re    (rd_en),
    .raddr (next_note[IDX_BITS-1:0]),
    .rdata (rd_word)
  );

  // The guard bit keeps the advanced position from overflowing at the top of the range.
  assign pos_inc = {1'b0, play_position} + (TIME_BITS + 1)'(1);

  always_comb begin
    if (state == WRAP) begin
      cmp_lhs = {1'b0, loop_length};
      cmp_rhs = pos_inc;
    end else begin
      cmp_lhs = {1'b0, rd_note.stamp};
      cmp_rhs = {1'b0, play_position};
    end
  end

  lerp_cmp u_cmp (
    .lhs (cmp_lhs),
    .rhs (cmp_rhs),
    .le  (cmp_le)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      is_recording  <= 1'b0;
      is_playing    <= 1'b0;
      play_fresh    <= 1'b0;
      record_clock  <= '0;
      loop_length   <= '0;
      play_position <= '0;
      next_note     <= '0;
      note_count    <= '0;
      have_pend     <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            case (code)
              REQ_TICK: begin
                // The record clock counts ticks and saturates at its maximum.
                if (is_recording && (record_clock != '1)) begin
                  record_clock <= record_clock + TIME_BITS'(1);
                end
                // Playback with no loop length set does nothing at all.
                if (is_playing && (loop_length != '0)) begin
                  have_pend <= 1'b0;
                  if (play_fresh) begin
                    // The first tick of a playback stays at position zero.
                    play_fresh <= 1'b0;
                    state      <= SCAN;
                  end else begin
                    state <= WRAP;
                  end
                end
              end
              REQ_KEY: begin
                if (store_key) begin
                  note_count <= note_count + CNT_BITS'(1);
                end
              end
              REQ_RECORD: begin
                if (is_recording) begin
                  // Stopping a recording fixes the loop length and toggles playback.
                  loop_length  <= record_clock;
                  is_recording <= 1'b0;
                  next_note    <= '0;
                  if (is_playing) begin
                    is_playing <= 1'b0;
                    play_fresh <= 1'b0;
                  end else begin
                    is_playing    <= 1'b1;
                    play_fresh    <= 1'b1;
                    play_position <= '0;
                  end
                end else begin
                  record_clock <= '0;
                  loop_length  <= '0;
                  note_count   <= '0;
                  is_recording <= 1'b1;
                end
              end
              REQ_PLAY: begin
                next_note <= '0;
                if (is_playing) begin
                  is_playing <= 1'b0;
                  play_fresh <= 1'b0;
                end else begin
                  is_playing    <= 1'b1;
                  play_fresh    <= 1'b1;
                  play_position <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        WRAP: begin
          // Reaching the loop length wraps the position and restarts the note walk.
          if (cmp_le) begin
            play_position <= '0;
            next_note     <= '0;
          end else begin
            play_position <= pos_inc[TIME_BITS-1:0];
          end
          state <= SCAN;
        end
        SCAN: begin
          if (more_notes) begin
            state <= CHK;
          end else begin
            if (have_pend) begin
              result_valid     <= 1'b1;
              result.note_key   <= pend.key;
              result.note_pitch <= pend.pitch;
              result.last_note  <= 1'b1;
            end
            have_pend <= 1'b0;
            state     <= IDLE;
          end
        end
        CHK: begin
          if (cmp_le) begin
            // This note is due, so the one held before it is not the last.
            if (have_pend) begin
              result_valid     <= 1'b1;
              result.note_key   <= pend.key;
              result.note_pitch <= pend.pitch;
              result.last_note  <= 1'b0;
            end
            pend      <= rd_note;
            have_pend <= 1'b1;
            next_note <= next_note + CNT_BITS'(1);
            state     <= SCAN;
          end else begin
            if (have_pend) begin
              result_valid     <= 1'b1;
              result.note_key   <= pend.key;
              result.note_pitch <= pend.pitch;
              result.last_note  <= 1'b1;
            end
            have_pend <= 1'b0;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A result only ever follows a cycle in which a tick was being walked.
  `ASSERT_IMPLIES(a_result_after_busy, result_valid, $past(busy))
  // The sequencer only runs while playback is on.
  `ASSERT_IMPLIES(a_busy_needs_play, busy, is_playing)
  // A note check always follows the read issued in the scan step.
  `ASSERT_IMPLIES(a_chk_after_scan, state == CHK, $past(state) == SCAN && $past(more_notes))
  // With a loop length set, the loop position stays inside the loop.
  `ASSERT_IMPLIES(a_pos_in_loop, is_playing && (loop_length != '0),
                  play_position < loop_length)

endmodule
